FILE: hw/rtl/assert_macros.svh
// Assertion helpers, included by cross_morphology_dilate_erode.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/cmde_pkg.sv
package cmde_pkg;

  // Pixel layout
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NUM_CH = 4;
  localparam int unsigned PIX_W  = CH_W * NUM_CH;

  // Size defaults
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;
  localparam int unsigned MAX_CHANNELS   = 4;

  // Op queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERODE_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd3;

  // Configuration reset values
  localparam logic [11:0] RST_IMAGE_WIDTH   = 12'd2048;
  localparam logic [11:0] RST_IMAGE_HEIGHT  = 12'd2048;
  localparam logic        RST_ERODE_MODE    = 1'b0;
  localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd4;

  // Control flags of one queued op
  typedef struct packed {
    logic wr;         // write the pixel into the line store
    logic emit;       // produce a result
    logic use_pix;    // incoming pixel takes part (lower neighbor)
    logic use_up;     // upper row takes part
    logic use_left;   // left neighbor takes part
    logic use_right;  // right neighbor takes part
    logic frame_end;  // final result of the frame
  } op_ctl_t;

endpackage

FILE: hw/rtl/cmde_front.sv
module cmde_front
  import cmde_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic             accept_i,
  input  logic             kind_i,
  input  logic [PIX_W-1:0] pix_i,
  input  logic [AW-1:0]    w_last_i,
  input  logic [RW-1:0]    h_last_i,
  output logic             push_o,
  output op_ctl_t          ctl_o,
  output logic [AW-1:0]    addr_o,
  output logic [AW-1:0]    addr_r_o,
  output logic [PIX_W-1:0] pix_o
);

  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          full_q, full_d;
  logic          last_col, last_row;

  assign last_col = (col_q == w_last_i);
  assign last_row = (row_q == h_last_i);
  assign addr_o   = col_q;
  assign addr_r_o = last_col ? col_q : col_q + AW'(1);
  assign pix_o    = pix_i;

  // Classify the item: pixel, drain tick, or drop; a restart clears the position
  always_comb begin
    push_o = 1'b0;
    ctl_o  = '0;
    col_d  = col_q;
    row_d  = row_q;
    full_d = full_q;
    if (accept_i) begin
      if (kind_i == KIND_PIXEL && !full_q) begin
        push_o          = 1'b1;
        ctl_o.wr        = 1'b1;
        ctl_o.emit      = (row_q != '0);
        ctl_o.use_pix   = 1'b1;
        ctl_o.use_up    = (row_q > RW'(1));
        ctl_o.use_left  = (col_q != '0);
        ctl_o.use_right = !last_col;
        if (last_col) begin
          col_d = '0;
          if (last_row) begin
            full_d = 1'b1;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          col_d = col_q + AW'(1);
        end
      end else if (kind_i == KIND_FLUSH && full_q) begin
        push_o          = 1'b1;
        ctl_o.emit      = 1'b1;
        ctl_o.use_up    = (h_last_i != '0);
        ctl_o.use_left  = (col_q != '0);
        ctl_o.use_right = !last_col;
        ctl_o.frame_end = last_col;
        if (last_col) begin
          col_d  = '0;
          row_d  = '0;
          full_d = 1'b0;
        end else begin
          col_d = col_q + AW'(1);
        end
      end
    end
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      full_d = 1'b0;
    end
  end

  // Advance frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      full_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      full_q <= full_d;
    end
  end

endmodule

FILE: hw/rtl/cmde_fifo.sv
module cmde_fifo
  import cmde_pkg::*;
#(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  logic [DW-1:0] buf_q [Q_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Hold queued ops
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/cmde_back.sv
module cmde_back
  import cmde_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  op_ctl_t          q_ctl_i,
  input  logic [AW-1:0]    q_addr_i,
  input  logic [AW-1:0]    q_addr_r_i,
  input  logic [PIX_W-1:0] q_pix_i,
  output logic             q_pop_o,
  input  logic             erode_i,
  input  logic [2:0]       ch_count_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CH_W-1:0]  out_c0_o,
  output logic [CH_W-1:0]  out_c1_o,
  output logic [CH_W-1:0]  out_c2_o,
  output logic [CH_W-1:0]  out_c3_o,
  output logic             frame_end_o
);

  // Line store word: upper row in the high half, middle row in the low half
  logic [2*PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [PIX_W-1:0]   rd_r_q;

  logic               b_valid_q;
  op_ctl_t            b_ctl_q;
  logic [AW-1:0]      b_addr_q;
  logic [PIX_W-1:0]   b_pix_q;
  logic               fwd_q, fwd_r_q;
  logic [2*PIX_W-1:0] fwd_wd_q;
  logic [PIX_W-1:0]   left_q;

  logic [PIX_W-1:0]   out_pix_q;
  logic               out_valid_q, out_end_q;

  logic [2*PIX_W-1:0] ent, wd;
  logic [PIX_W-1:0]   mid, up, right;
  logic [PIX_W-1:0]   c_pix, c_up, c_left, c_right, acc;
  logic               out_free, b_adv, b_wr;

  function automatic logic [CH_W-1:0] pick8(input logic [CH_W-1:0] a,
                                            input logic [CH_W-1:0] b,
                                            input logic            mn);
    logic lt;
    lt = (a < b);
    return (lt == mn) ? a : b;
  endfunction

  // Resolve the neighborhood, bypassing a write made as the read went out
  assign ent   = fwd_q ? fwd_wd_q : rd_q;
  assign mid   = ent[PIX_W-1:0];
  assign up    = ent[2*PIX_W-1:PIX_W];
  assign right = fwd_r_q ? fwd_wd_q[PIX_W-1:0] : rd_r_q;
  assign wd    = {mid, b_pix_q};

  // Skipped neighbors fall back to the center, which always takes part
  assign c_pix   = b_ctl_q.use_pix   ? b_pix_q : mid;
  assign c_up    = b_ctl_q.use_up    ? up      : mid;
  assign c_left  = b_ctl_q.use_left  ? left_q  : mid;
  assign c_right = b_ctl_q.use_right ? right   : mid;

  // Per-channel maximum or minimum, unused channels forced to zero
  always_comb begin
    logic [CH_W-1:0] m1, m2, m3, m4;
    acc = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      m1 = pick8(c_pix[c*CH_W +: CH_W], mid[c*CH_W +: CH_W], erode_i);
      m2 = pick8(c_up[c*CH_W +: CH_W], c_left[c*CH_W +: CH_W], erode_i);
      m3 = pick8(m1, m2, erode_i);
      m4 = pick8(m3, c_right[c*CH_W +: CH_W], erode_i);
      if ((3'(c) < ch_count_i) && (c < MAX_CHANNELS)) begin
        acc[c*CH_W +: CH_W] = m4;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign b_adv    = !b_valid_q || !b_ctl_q.emit || out_free;
  assign b_wr     = b_valid_q && b_adv && b_ctl_q.wr;
  assign q_pop_o  = q_valid_i && b_adv;

  // Line store: read at issue, write when the op retires
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_q   <= mem_q[q_addr_i];
      rd_r_q <= mem_q[q_addr_r_i][PIX_W-1:0];
    end
    if (b_wr) begin
      mem_q[b_addr_q] <= wd;
    end
  end

  // Load the execute stage, bypass data, left neighbor and output register
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_ctl_q  <= q_ctl_i;
      b_addr_q <= q_addr_i;
      b_pix_q  <= q_pix_i;
      fwd_q    <= b_wr && (b_addr_q == q_addr_i);
      fwd_r_q  <= b_wr && (b_addr_q == q_addr_r_i);
      fwd_wd_q <= wd;
    end
    if (b_valid_q && b_adv) begin
      left_q <= mid;
    end
    if (b_valid_q && b_adv && b_ctl_q.emit) begin
      out_pix_q <= acc;
      out_end_q <= b_ctl_q.frame_end;
    end
  end

  // Advance execute and output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_valid_q && b_adv && b_ctl_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_c0_o    = out_pix_q[0*CH_W +: CH_W];
  assign out_c1_o    = out_pix_q[1*CH_W +: CH_W];
  assign out_c2_o    = out_pix_q[2*CH_W +: CH_W];
  assign out_c3_o    = out_pix_q[3*CH_W +: CH_W];
  assign frame_end_o = out_end_q;

endmodule

FILE: hw/rtl/cross_morphology_dilate_erode.sv
// Order: the item that completes a result (the pixel below, or a drain tick for
// the last row) passes the op queue, the execute stage and the output register.
// Throughput: one item per cycle, stalls aside; the line store has one write port.
// Reset: counters, queue and valid flags clear; registers take their defaults;
// the line store is not cleared and needs no clearing pass.
module cross_morphology_dilate_erode
  import cmde_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [CH_W-1:0]       in_c0_i,
  input  logic [CH_W-1:0]       in_c1_i,
  input  logic [CH_W-1:0]       in_c2_i,
  input  logic [CH_W-1:0]       in_c3_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CH_W-1:0]       out_c0_o,
  output logic [CH_W-1:0]       out_c1_o,
  output logic [CH_W-1:0]       out_c2_o,
  output logic [CH_W-1:0]       out_c3_o,
  output logic                  frame_end_o
);

  `include "assert_macros.svh"

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CTL_W = $bits(op_ctl_t);
  localparam int unsigned QW = CTL_W + 2 * AW + PIX_W;

  logic [11:0] cfg_width_q, cfg_height_q;
  logic        cfg_erode_q;
  logic [2:0]  cfg_count_q;

  logic [AW-1:0]    w_last;
  logic [RW-1:0]    h_last;
  logic             accept;
  logic             q_push, q_full, q_valid, q_pop;
  op_ctl_t          f_ctl, q_ctl;
  logic [AW-1:0]    f_addr, f_addr_r, q_addr, q_addr_r;
  logic [PIX_W-1:0] f_pix, q_pix;
  logic [QW-1:0]    q_wdata, q_rdata;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_IMAGE_WIDTH;
      cfg_height_q <= RST_IMAGE_HEIGHT;
      cfg_erode_q  <= RST_ERODE_MODE;
      cfg_count_q  <= RST_CHANNEL_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:   cfg_width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT:  cfg_height_q <= cfg_wdata_i;
        CFG_ERODE_MODE:    cfg_erode_q  <= cfg_wdata_i[0];
        CFG_CHANNEL_COUNT: cfg_count_q  <= cfg_wdata_i[2:0];
        default:           cfg_count_q  <= cfg_count_q;
      endcase
    end
  end

  // Clamp frame size into range, as last column and last row
  always_comb begin
    if (cfg_width_q == '0) begin
      w_last = '0;
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      w_last = AW'(MAX_WIDTH - 1);
    end else begin
      w_last = AW'(cfg_width_q - 12'd1);
    end
    if (cfg_height_q == '0) begin
      h_last = '0;
    end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(cfg_height_q - 12'd1);
    end
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  cmde_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .restart_i(cfg_we_i),
    .accept_i (accept),
    .kind_i   (kind_i),
    .pix_i    ({in_c3_i, in_c2_i, in_c1_i, in_c0_i}),
    .w_last_i (w_last),
    .h_last_i (h_last),
    .push_o   (q_push),
    .ctl_o    (f_ctl),
    .addr_o   (f_addr),
    .addr_r_o (f_addr_r),
    .pix_o    (f_pix)
  );

  assign q_wdata = {f_ctl, f_addr, f_addr_r, f_pix};
  assign {q_ctl, q_addr, q_addr_r, q_pix} = q_rdata;

  cmde_fifo #(
    .DW(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  cmde_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ctl_i    (q_ctl),
    .q_addr_i   (q_addr),
    .q_addr_r_i (q_addr_r),
    .q_pix_i    (q_pix),
    .q_pop_o    (q_pop),
    .erode_i    (cfg_erode_q),
    .ch_count_i (cfg_count_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_c0_o   (out_c0_o),
    .out_c1_o   (out_c1_o),
    .out_c2_o   (out_c2_o),
    .out_c3_o   (out_c3_o),
    .frame_end_o(frame_end_o)
  );

  // Queue never overflows or underflows
  `ASSERT_NEVER(a_queue_no_overflow, q_push && q_full, "op pushed into full queue")
  `ASSERT_NEVER(a_queue_no_underflow, q_pop && !q_valid, "op popped from empty queue")
  // A result that the sink has not taken stays valid on the next edge
  `ASSERT_CLK(a_result_kept, out_valid_o && out_stall_i |=> out_valid_o, "stalled result lost")

endmodule
